>>> rtl/assert_macros.svh
// Assertion macros used by the RTL of the infraction ban table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge of clk outside reset.
`define IBAN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that an expression is never true outside reset.
`define IBAN_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define IBAN_ASSERT(lbl, prop, msg)
`define IBAN_NEVER(lbl, expr, msg)
`endif

`endif

>>> rtl/iban_pkg.sv
// Types and constants of the infraction ban table.
`default_nettype none
package iban_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [31:0] address;
        logic [7:0]  count;
        logic [31:0] stamp;
    } rec_t;

    localparam logic       CMD_CHECK      = 1'b0;
    localparam logic       CMD_ADD        = 1'b1;

    localparam logic       CFG_COOLDOWN   = 1'b0;
    localparam logic       CFG_THRESHOLD  = 1'b1;

    localparam logic [2:0] STS_NOT_BANNED = 3'd0;
    localparam logic [2:0] STS_BANNED     = 3'd1;
    localparam logic [2:0] STS_ADDED      = 3'd2;
    localparam logic [2:0] STS_UPDATED    = 3'd3;
    localparam logic [2:0] STS_FULL       = 3'd4;

    localparam logic [31:0] COOLDOWN_RESET  = 32'd86400;
    localparam logic [7:0]  THRESHOLD_RESET = 8'd3;
    localparam logic [7:0]  COUNT_MAX       = 8'd255;

endpackage
`default_nettype wire

>>> rtl/ip_infraction_ban_table_core.sv
// Top level of the IPv4 infraction ban table with expiring records.
// Usage:
//   Input channel (in_valid/in_ready): one transaction carries command,
//   ip_address and now_seconds. command 0 checks an address, 1 records an
//   infraction. Output channel (out_valid/out_ready): one transaction per
//   input carries banned and status.
//   Configuration: cfg_we writes cfg_data into register cfg_index (0 cooldown,
//   1 ban threshold) at the same edge; write only while the block is idle.
// Sequence:
//   From the accepting edge the block sweeps every entry, one entry per
//   cycle through the registered RAM read and one shared subtract/compare
//   unit, then commits the result. in_ready returns in the same cycle as
//   the result becomes valid, so a new transaction is taken only after the
//   last one has committed.
// Reset:
//   All valid bits clear at once, so the table is empty; registers return to
//   cooldown 86400 and threshold 3. No clearing pass is needed.
// Stall:
//   A finished result holds in the output register until taken; the next
//   transaction is accepted meanwhile, and its commit waits for the slot.
`default_nettype none
`include "assert_macros.svh"
module ip_infraction_ban_table_core
    import iban_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        command,
    input  wire logic [31:0] ip_address,
    input  wire logic [31:0] now_seconds,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             banned,
    output logic [2:0]       status,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int IDXW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNTW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNTW-1:0] CNT_END = CNTW'(TABLE_ENTRIES);
    localparam int RECW = $bits(rec_t);

    // Sequencer and configuration
    state_t            state_reg, state_next;
    logic [31:0]       cooldown_reg;
    logic [7:0]        threshold_reg;

    // Latched transaction
    logic              cmd_reg, cmd_next;
    logic [31:0]       addr_reg, addr_next;
    logic [31:0]       now_reg, now_next;

    // Sweep state
    logic [CNTW-1:0]   cnt_reg, cnt_next;
    logic [IDXW-1:0]   eval_idx_reg, eval_idx_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic              hit_reg, hit_next;
    logic [IDXW-1:0]   hit_idx_reg, hit_idx_next;
    logic [7:0]        hit_count_reg, hit_count_next;
    logic              free_reg, free_next;
    logic [IDXW-1:0]   free_idx_reg, free_idx_next;

    // Result register
    logic              out_valid_reg, out_valid_next;
    logic              banned_reg, banned_next;
    logic [2:0]        status_reg, status_next;

    // Control strobes
    logic              accept;
    logic              ram_re;
    logic              eval_en;
    logic              commit;

    // RAM ports
    logic              ram_we;
    logic [IDXW-1:0]   ram_waddr;
    rec_t              ram_wdata;
    rec_t              ram_rdata;
    logic [RECW-1:0]   ram_rbits;

    // Shared compare unit
    logic [31:0]       age;
    logic              entry_valid;
    logic              expired;
    logic [7:0]        count_inc;

    iban_ram #(
        .WIDTH (RECW),
        .DEPTH (TABLE_ENTRIES)
    ) u_rec_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (cnt_reg[IDXW-1:0]),
        .rdata (ram_rbits)
    );

    assign ram_rdata = rec_t'(ram_rbits);

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign banned    = banned_reg;
    assign status    = status_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == CNT_END)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        accept  = 1'b0;
        ram_re  = 1'b0;
        eval_en = 1'b0;
        commit  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                accept = in_valid;
            end
            ST_SCAN:
            begin
                ram_re  = (cnt_reg < CNT_END);
                eval_en = (cnt_reg != '0);
            end
            ST_FINISH:
            begin
                commit = !out_valid_reg || out_ready;
            end
            default:
            begin
                accept = 1'b0;
            end
        endcase
    end

    // Age and match unit, used once per swept entry
    assign entry_valid = valid_reg[eval_idx_reg];
    assign age         = now_reg - ram_rdata.stamp;
    assign expired     = entry_valid && (age > cooldown_reg);
    assign count_inc   = (hit_count_reg == COUNT_MAX) ? hit_count_reg : hit_count_reg + 8'd1;

    // Datapath
    always_comb
    begin
        cmd_next       = cmd_reg;
        addr_next      = addr_reg;
        now_next       = now_reg;
        cnt_next       = cnt_reg;
        eval_idx_next  = eval_idx_reg;
        valid_next     = valid_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_count_next = hit_count_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        banned_next    = banned_reg;
        status_next    = status_reg;
        ram_we         = 1'b0;
        ram_waddr      = hit_idx_reg;
        ram_wdata      = '{address: addr_reg, count: hit_count_reg, stamp: now_reg};

        if (accept)
        begin
            cmd_next  = command;
            addr_next = ip_address;
            now_next  = now_seconds;
            cnt_next  = '0;
            hit_next  = 1'b0;
            free_next = 1'b0;
        end

        if (ram_re)
        begin
            cnt_next      = cnt_reg + CNTW'(1);
            eval_idx_next = cnt_reg[IDXW-1:0];
        end

        if (eval_en)
        begin
            // Drop the expired record; it becomes a free slot
            if (expired)
            begin
                valid_next[eval_idx_reg] = 1'b0;
            end
            if (entry_valid && !expired && !hit_reg && ram_rdata.address == addr_reg)
            begin
                hit_next       = 1'b1;
                hit_idx_next   = eval_idx_reg;
                hit_count_next = ram_rdata.count;
            end
            if ((!entry_valid || expired) && !free_reg)
            begin
                free_next     = 1'b1;
                free_idx_next = eval_idx_reg;
            end
        end

        if (commit)
        begin
            out_valid_next = 1'b1;
            banned_next    = 1'b0;
            if (cmd_reg == CMD_CHECK)
            begin
                if (hit_reg && hit_count_reg >= threshold_reg)
                begin
                    ram_we      = 1'b1;
                    banned_next = 1'b1;
                    status_next = STS_BANNED;
                end
                else
                begin
                    status_next = STS_NOT_BANNED;
                end
            end
            else if (hit_reg)
            begin
                ram_we          = 1'b1;
                ram_wdata.count = count_inc;
                if (count_inc >= threshold_reg)
                begin
                    banned_next = 1'b1;
                    status_next = STS_BANNED;
                end
                else
                begin
                    status_next = STS_UPDATED;
                end
            end
            else if (free_reg)
            begin
                ram_we                   = 1'b1;
                ram_waddr                = free_idx_reg;
                ram_wdata.count          = 8'd1;
                valid_next[free_idx_reg] = 1'b1;
                status_next              = STS_ADDED;
            end
            else
            begin
                status_next = STS_FULL;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            cooldown_reg  <= COOLDOWN_RESET;
            threshold_reg <= THRESHOLD_RESET;
            cnt_reg       <= '0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_COOLDOWN:  cooldown_reg  <= cfg_data;
                    CFG_THRESHOLD: threshold_reg <= cfg_data[7:0];
                    default:       cooldown_reg  <= cooldown_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        addr_reg      <= addr_next;
        now_reg       <= now_next;
        eval_idx_reg  <= eval_idx_next;
        hit_idx_reg   <= hit_idx_next;
        hit_count_reg <= hit_count_next;
        free_idx_reg  <= free_idx_next;
        banned_reg    <= banned_next;
        status_reg    <= status_next;
    end

    `IBAN_ASSERT(a_accept_starts_scan, (in_valid && in_ready) |=> (state_reg == ST_SCAN), "accepted transaction did not start a sweep")
    `IBAN_ASSERT(a_finish_after_sweep, (state_reg == ST_FINISH) |-> (cnt_reg == CNT_END), "commit reached before the sweep ended")
    `IBAN_ASSERT(a_banned_matches_status, out_valid_reg |-> (banned_reg == (status_reg == STS_BANNED)), "banned flag disagrees with status")
    `IBAN_NEVER(a_insert_into_used, commit && ram_we && !hit_reg && (cmd_reg == CMD_ADD) && valid_reg[free_idx_reg], "insert overwrote a valid record")

endmodule
`default_nettype wire

>>> rtl/iban_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module iban_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule
`default_nettype wire

>>> dv/tb_ip_infraction_ban_table_core.sv
// Testbench for the IPv4 infraction ban table: directed and random transactions checked by a local table model.
module tb_ip_infraction_ban_table_core;
    timeunit 1ns;
    timeprecision 1ps;

    import iban_pkg::*;

    localparam int TABLE_DEPTH    = 16;
    // Covers the accept, the sweep over every entry and the commit.
    localparam int RESULT_LATENCY = TABLE_DEPTH + 3;
    localparam int RANDOM_ITEMS   = 520;
    localparam int RANDOM_PHASES  = 8;
    // The limit leaves a wide margin for about 800 transactions, even with the
    // longest gaps on both sides.
    localparam int CYCLE_LIMIT    = 1_000_000;

    typedef struct packed {
        logic       banned;
        logic [2:0] status;
    } verdict_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        command;
    logic [31:0] ip_address;
    logic [31:0] now_seconds;
    logic        out_valid;
    logic        out_ready;
    logic        banned;
    logic [2:0]  status;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;

    // Local copy of the ban table and its two registers.
    logic        tbl_valid [TABLE_DEPTH];
    logic [31:0] tbl_addr  [TABLE_DEPTH];
    logic [7:0]  tbl_count [TABLE_DEPTH];
    logic [31:0] tbl_stamp [TABLE_DEPTH];
    logic [31:0] model_cooldown;
    logic [7:0]  model_threshold;

    verdict_t    pending_verdicts [$];

    logic [31:0] stim_time;
    bit          tx_gaps_on   = 1'b1;
    bit          rx_stalls_on = 1'b1;
    int          ready_hold   = 0;
    int          cycle_count  = 0;
    int          items_accepted  = 0;
    int          results_checked = 0;
    int          mismatches      = 0;
    int          reg_writes      = 0;
    int          status_seen [8] = '{default: 0};

    ip_infraction_ban_table_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .ip_address  (ip_address),
        .now_seconds (now_seconds),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .banned      (banned),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pending_verdicts.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Gap length for both sides: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Apply one transaction to the local table and return what the block must
    // answer. Expire first, then look up, then check, update or insert.
    function automatic verdict_t apply_transaction(input logic cmd, input logic [31:0] addr,
                                                   input logic [31:0] now);
        verdict_t    v;
        int          hit;
        int          slot;
        logic [31:0] age;
        v    = '0;
        hit  = -1;
        slot = -1;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            // Age wraps with the seconds counter.
            age = now - tbl_stamp[i];
            if (tbl_valid[i] && age > model_cooldown)
                tbl_valid[i] = 1'b0;
        end
        // Walk downward so the lowest matching and lowest free entries win.
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (tbl_valid[i] && tbl_addr[i] == addr)
                hit = i;
            if (!tbl_valid[i])
                slot = i;
        end
        if (cmd == CMD_CHECK)
        begin
            if (hit >= 0 && tbl_count[hit] >= model_threshold)
            begin
                tbl_stamp[hit] = now;
                v.banned = 1'b1;
                v.status = STS_BANNED;
            end
            else
                v.status = STS_NOT_BANNED;
        end
        else if (hit >= 0)
        begin
            if (tbl_count[hit] != COUNT_MAX)
                tbl_count[hit]++;
            tbl_stamp[hit] = now;
            if (tbl_count[hit] >= model_threshold)
            begin
                v.banned = 1'b1;
                v.status = STS_BANNED;
            end
            else
                v.status = STS_UPDATED;
        end
        else if (slot >= 0)
        begin
            // A fresh record is never reported as banned, whatever the threshold.
            tbl_valid[slot] = 1'b1;
            tbl_addr[slot]  = addr;
            tbl_count[slot] = 8'd1;
            tbl_stamp[slot] = now;
            v.status        = STS_ADDED;
        end
        else
            v.status = STS_FULL;
        return v;
    endfunction

    // Sample both channels and the config port at the rising edge. Check the
    // outgoing result before queueing the incoming one, so a same-edge pair
    // stays in order.
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_checked++;
                if (pending_verdicts.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with nothing expected, banned %0d status %0d",
                             $time, banned, status);
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    status_seen[want.status]++;
                    if (banned !== want.banned)
                    begin
                        mismatches++;
                        $display("%0t: banned mismatch, expected %0d, actual %0d",
                                 $time, want.banned, banned);
                    end
                    if (status !== want.status)
                    begin
                        mismatches++;
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, status);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                items_accepted++;
                pending_verdicts.insert(pending_verdicts.size(),
                                        apply_transaction(command, ip_address, now_seconds));
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_COOLDOWN)
                    model_cooldown = cfg_data;
                else
                    model_threshold = cfg_data[7:0];
            end
        end
    end

    // Drive out_ready: hold it low for random stretches while stalls are enabled.
    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            out_ready <= 1'b0;
            ready_hold--;
        end
        else
        begin
            out_ready <= 1'b1;
            if (rx_stalls_on && $urandom_range(0, 3) == 0)
                ready_hold = pick_gap();
        end
    end

    // Offer one transaction and return at the edge that accepts it. Valid stays
    // high afterwards so back-to-back items need no extra edge.
    task automatic send_transaction(input logic cmd, input logic [31:0] addr,
                                    input logic [31:0] now);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        ip_address  <= addr;
        now_seconds <= now;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        reg_writes++;
    endtask

    task automatic configure(input logic [31:0] cool, input logic [7:0] thr);
        write_reg(CFG_COOLDOWN, cool);
        write_reg(CFG_THRESHOLD, {24'd0, thr});
    endtask

    // Reset register values: add, update, ban, then expire exactly one second
    // past the cooldown.
    task automatic test_reset_values();
        stim_time = 32'h0000_1000;
        send_transaction(CMD_ADD,   32'h0000_0000, stim_time);
        send_transaction(CMD_CHECK, 32'h0000_0000, stim_time);
        send_transaction(CMD_ADD,   32'h0000_0000, stim_time);
        send_transaction(CMD_ADD,   32'h0000_0000, stim_time);
        // An age equal to the cooldown keeps the record.
        stim_time = stim_time + COOLDOWN_RESET;
        send_transaction(CMD_CHECK, 32'h0000_0000, stim_time);
        send_transaction(CMD_CHECK, 32'hFFFF_FFFF, stim_time);
        send_transaction(CMD_ADD,   32'hFFFF_FFFF, stim_time);
        stim_time = stim_time + COOLDOWN_RESET + 1;
        send_transaction(CMD_CHECK, 32'h0000_0000, stim_time);
    endtask

    // Fill all entries, then overflow with one more new address.
    task automatic test_table_full();
        logic [31:0] base;
        base = $urandom;
        configure(32'hFFFF_FFFF, COUNT_MAX);
        stim_time = stim_time + 32'd10;
        for (int i = 0; i <= TABLE_DEPTH; i++)
            send_transaction(CMD_ADD, {base[31:5], 5'(i)}, stim_time);
        send_transaction(CMD_ADD,   {base[31:5], 5'd2}, stim_time);
        send_transaction(CMD_CHECK, {base[31:5], 5'd2}, stim_time);
    endtask

    // Zero cooldown across the counter wrap, a cooldown boundary across the
    // wrap, and thresholds of one and zero.
    task automatic test_wrap_and_thresholds();
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        a = $urandom;
        b = ~a;
        c = a ^ 32'h5A5A_0001;
        configure(32'd0, 8'd1);
        send_transaction(CMD_ADD,   a, 32'hFFFF_FFFF);
        send_transaction(CMD_ADD,   a, 32'hFFFF_FFFF);
        send_transaction(CMD_CHECK, a, 32'h0000_0000);
        write_reg(CFG_COOLDOWN, 32'd5);
        send_transaction(CMD_ADD,   b, 32'hFFFF_FFFE);
        send_transaction(CMD_ADD,   b, 32'd3);
        send_transaction(CMD_CHECK, b, 32'd9);
        write_reg(CFG_THRESHOLD, 32'd0);
        send_transaction(CMD_ADD,   c, 32'd20);
        send_transaction(CMD_CHECK, c, 32'd20);
        send_transaction(CMD_CHECK, ~c, 32'd20);
        stim_time = 32'd20;
    endtask

    // Push one address past 255 infractions; the count must stick at the top.
    task automatic test_count_saturation();
        logic [31:0] addr;
        addr = $urandom;
        configure(32'hFFFF_FFFF, COUNT_MAX);
        for (int n = 0; n < 257; n++)
        begin
            stim_time = stim_time + $urandom_range(0, 50);
            send_transaction(CMD_ADD, addr, stim_time);
        end
        send_transaction(CMD_CHECK, addr, stim_time);
    endtask

    // Random traffic in phases, each with its own register setting and its own
    // small pool of addresses so that records repeat, ban and expire.
    task automatic test_random_traffic();
        logic [31:0] pool [24];
        logic [31:0] cool;
        logic [7:0]  thr;
        logic [31:0] step;
        logic [31:0] addr;
        logic        cmd;
        int          pool_n;
        int          r;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: begin cool = COOLDOWN_RESET;            thr = THRESHOLD_RESET;           end
                1: begin cool = $urandom;                  thr = 8'($urandom_range(1, 255)); end
                2: begin cool = 32'd0;                     thr = 8'd1;                      end
                3: begin cool = 32'hFFFF_FFFF;             thr = 8'd2;                      end
                4: begin cool = 32'd20;                    thr = 8'($urandom_range(1, 4));  end
                5: begin cool = $urandom_range(1, 100);    thr = 8'd1;                      end
                6: begin cool = 32'd1000;                  thr = COUNT_MAX;                 end
                default: begin cool = 32'd60;              thr = THRESHOLD_RESET;           end
            endcase
            configure(cool, thr);
            // Leave some phases free of idling on one side or both.
            tx_gaps_on   = (p != 3 && p != RANDOM_PHASES - 1);
            rx_stalls_on = (p != 5 && p != RANDOM_PHASES - 1);
            pool_n = $urandom_range(4, 24);
            for (int k = 0; k < pool_n; k++)
                pool[k] = $urandom;
            stim_time = $urandom;
            for (int n = 0; n < RANDOM_ITEMS / RANDOM_PHASES; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    step = $urandom_range(0, 2);
                else if (r < 90)
                    step = $urandom_range(0, (cool < 64) ? cool + 2 : 64);
                else if (r < 96)
                    step = cool + $urandom_range(0, 1);
                else
                    step = $urandom;    // jump, possibly backward
                stim_time = stim_time + step;
                addr = ($urandom_range(0, 9) == 0) ? $urandom
                                                   : pool[$urandom_range(0, pool_n - 1)];
                cmd  = ($urandom_range(0, 99) < 65) ? CMD_ADD : CMD_CHECK;
                send_transaction(cmd, addr, stim_time);
            end
        end
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    initial
    begin
        // Drive every input to a known value before the first edge.
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        command     = CMD_CHECK;
        ip_address  = '0;
        now_seconds = '0;
        out_ready   = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_COOLDOWN;
        cfg_data    = '0;
        stim_time   = '0;
        // Reset state of the local table: empty, registers at their defaults.
        model_cooldown  = COOLDOWN_RESET;
        model_threshold = THRESHOLD_RESET;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_addr[i]  = '0;
            tbl_count[i] = '0;
            tbl_stamp[i] = '0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_values();
        test_table_full();
        test_wrap_and_thresholds();
        test_count_saturation();
        test_random_traffic();

        // Drain, then give the pipeline a full pass to show any stray result.
        settle();
        repeat (RESULT_LATENCY + 5) @(posedge clk);
        if (pending_verdicts.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d results never arrived", $time, pending_verdicts.size());
        end

        $display("Run covered %0d transactions, %0d results checked, %0d register writes",
                 items_accepted, results_checked, reg_writes);
        $display("Outcomes: not banned %0d, banned %0d, added %0d, updated %0d, full %0d",
                 status_seen[STS_NOT_BANNED], status_seen[STS_BANNED],
                 status_seen[STS_ADDED], status_seen[STS_UPDATED], status_seen[STS_FULL]);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/iban_pkg.sv
rtl/iban_ram.sv
rtl/ip_infraction_ban_table_core.sv
dv/tb_ip_infraction_ban_table_core.sv
